[hdl/box_blur_3x3_edge_average_top_defines.svh]
// Assertion macros for the box blur block.
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_TOP_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define BB3_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define BB3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/bb3_pkg.sv]
`default_nettype none

package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int NUM_W     = 13;
    localparam int RECIP_W   = 18;
    localparam int RECIP_SH  = 18;
    localparam int PROD_W    = NUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            frame_last;
    } result_t;

    // ceil(2^18 / (2*count)); exact quotient for numerators below 2^13
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        begin
            unique case (count)
                4'd2:    m = 18'd65536;
                4'd3:    m = 18'd43691;
                4'd4:    m = 18'd32768;
                4'd6:    m = 18'd21846;
                4'd9:    m = 18'd14564;
                default: m = 18'd131072;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/box_blur_3x3_edge_average_top.sv]
// Path: a result moves through the stage-1, stage-2 and output registers after the item that
//   completes its window is accepted; results trail the pixel stream by one row plus one pixel.
// Throughput: one item per cycle unless result_ready stalls; set by one read and write port per line store.
// Reset (rst_n, async, active low): width and height return to 1, counters and window clear;
//   line store contents are left as they are.
`default_nettype none
`include "box_blur_3x3_edge_average_top_defines.svh"

module box_blur_3x3_edge_average_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 pixel_valid,
    output logic                                pixel_ready,
    input  wire bb3_pkg::pixel_t                pixel,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output bb3_pkg::result_t                    result,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [bb3_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [bb3_pkg::CFG_DAT_W-1:0]        cfg_data
);

    localparam int AW = bb3_pkg::ADDR_W;
    localparam int PW = bb3_pkg::PIX_W;
    localparam int CW = bb3_pkg::CH_W;

    logic [bb3_pkg::FW_W-1:0] fw_reg, fw_next;
    logic [bb3_pkg::FH_W-1:0] fh_reg, fh_next;
    logic [AW-1:0]            wm1;
    logic [bb3_pkg::FH_W-1:0] hm1;
    logic                     cfg_write;
    logic                     cfg_restart;

    logic [AW-1:0]            col_reg, col_next;
    logic [1:0]               row_reg, row_next;
    logic [AW-1:0]            cc_reg, cc_next;
    logic [bb3_pkg::FH_W-1:0] rc_reg, rc_next;

    logic                     adv;
    logic                     accept;
    logic [AW-1:0]            ic;
    logic                     wrap;
    logic                     emit;
    logic                     last;
    logic [3:0]               mask;

    logic [PW-1:0]            upper_mem [bb3_pkg::MAX_WIDTH];
    logic [PW-1:0]            middle_mem [bb3_pkg::MAX_WIDTH];
    logic [PW-1:0]            up_rd_reg;
    logic [PW-1:0]            mid_rd_reg;

    logic                     s1_valid_reg;
    logic                     s1_emit_reg;
    logic                     s1_last_reg;
    logic [3:0]               s1_mask_reg;
    logic [AW-1:0]            s1_ic_reg;
    logic [PW-1:0]            s1_cur_reg;
    logic                     fwd_reg;
    logic [PW-1:0]            fwd_up_reg;
    logic [PW-1:0]            fwd_mid_reg;
    logic                     s1_write;
    logic [PW-1:0]            cur;
    logic [PW-1:0]            up_eff;
    logic [PW-1:0]            mid_eff;

    logic [PW-1:0]            win_reg [9];
    logic [PW-1:0]            win_next [9];
    logic [8:0]               incl;
    logic [bb3_pkg::SUM_W-1:0] sum [3];
    logic [bb3_pkg::CNT_W-1:0] count;
    logic [bb3_pkg::NUM_W-1:0] num [3];

    logic                      s2_valid_reg;
    logic                      s2_last_reg;
    logic [bb3_pkg::NUM_W-1:0] s2_num_reg [3];
    logic [bb3_pkg::RECIP_W-1:0] s2_m_reg;
    logic [bb3_pkg::PROD_W-1:0] prod [3];

    logic                      out_valid_reg;
    bb3_pkg::result_t          out_reg;

    // effective frame size
    always_comb
    begin
        if (fw_reg == '0)
            wm1 = '0;
        else if (fw_reg > bb3_pkg::FW_W'(bb3_pkg::MAX_WIDTH))
            wm1 = AW'(bb3_pkg::MAX_WIDTH - 1);
        else
            wm1 = AW'(fw_reg - 1'b1);
        hm1 = (fh_reg == '0) ? '0 : fh_reg - 1'b1;
    end

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        fw_next     = fw_reg;
        fh_next     = fh_reg;
        cfg_restart = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bb3_pkg::CFG_FRAME_WIDTH:
                begin
                    fw_next     = cfg_data[bb3_pkg::FW_W-1:0];
                    cfg_restart = 1'b1;
                end
                bb3_pkg::CFG_FRAME_HEIGHT:
                begin
                    fh_next     = cfg_data;
                    cfg_restart = 1'b1;
                end
                default:
                begin
                    fw_next = fw_reg;
                end
            endcase
        end
    end

    assign adv         = !out_valid_reg || result_ready;
    assign pixel_ready = adv;
    assign accept      = pixel_valid && adv;

    // position bookkeeping, all settled at acceptance
    always_comb
    begin
        ic   = (col_reg > wm1) ? '0 : col_reg;
        wrap = (ic == wm1);
        emit = (row_reg == 2'd2) || ((row_reg == 2'd1) && (ic != '0));
        last = emit && (cc_reg == wm1) && (rc_reg == hm1);
        mask = {rc_reg != hm1, rc_reg != '0, cc_reg != wm1, cc_reg != '0};

        col_next = col_reg;
        row_next = row_reg;
        cc_next  = cc_reg;
        rc_next  = rc_reg;
        if (cfg_restart || (accept && last))
        begin
            col_next = '0;
            row_next = '0;
            cc_next  = '0;
            rc_next  = '0;
        end
        else if (accept)
        begin
            col_next = wrap ? '0 : ic + 1'b1;
            if (wrap && (row_reg != 2'd2))
                row_next = row_reg + 1'b1;
            if (emit)
            begin
                if (cc_reg == wm1)
                begin
                    cc_next = '0;
                    rc_next = rc_reg + 1'b1;
                end
                else
                begin
                    cc_next = cc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= bb3_pkg::FW_W'(1);
            fh_reg  <= bb3_pkg::FH_W'(1);
            col_reg <= '0;
            row_reg <= '0;
            cc_reg  <= '0;
            rc_reg  <= '0;
        end
        else
        begin
            fw_reg  <= fw_next;
            fh_reg  <= fh_next;
            col_reg <= col_next;
            row_reg <= row_next;
            cc_reg  <= cc_next;
            rc_reg  <= rc_next;
        end
    end

    assign cur = (pixel.cmd == bb3_pkg::CMD_FLUSH) ? '0
                 : {pixel.in_red, pixel.in_green, pixel.in_blue};

    // line stores: read on accept, write back from the stage-1 registers
    assign up_eff   = fwd_reg ? fwd_up_reg  : up_rd_reg;
    assign mid_eff  = fwd_reg ? fwd_mid_reg : mid_rd_reg;
    assign s1_write = adv && s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            upper_mem[s1_ic_reg]  <= mid_eff;
            middle_mem[s1_ic_reg] <= s1_cur_reg;
        end
        if (accept)
        begin
            up_rd_reg  <= upper_mem[ic];
            mid_rd_reg <= middle_mem[ic];
        end
    end

    // stage-1 capture, and forwarding for a same-column read while the write is in flight (single-pixel rows)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_mask_reg <= mask;
            s1_ic_reg   <= ic;
            s1_cur_reg  <= cur;
            fwd_reg     <= s1_valid_reg && (s1_ic_reg == ic);
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= s1_cur_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            win_next[k] = win_reg[k + 3];
        win_next[6] = up_eff;
        win_next[7] = mid_eff;
        win_next[8] = s1_cur_reg;
    end

    // bits of mask: left, right (columns), top, bottom (rows)
    always_comb
    begin
        for (int dc = 0; dc < 3; dc++)
        begin
            for (int dr = 0; dr < 3; dr++)
            begin
                incl[dc * 3 + dr] = ((dc != 0) || s1_mask_reg[0])
                                 && ((dc != 2) || s1_mask_reg[1])
                                 && ((dr != 0) || s1_mask_reg[2])
                                 && ((dr != 2) || s1_mask_reg[3]);
            end
        end
        count = bb3_pkg::CNT_W'($countones(incl));
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int k = 0; k < 9; k++)
            begin
                if (incl[k])
                    sum[ch] = sum[ch]
                            + bb3_pkg::SUM_W'(win_next[k][PW - 1 - ch * CW -: CW]);
            end
            num[ch] = {sum[ch], 1'b0} + bb3_pkg::NUM_W'(count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (s1_write)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= win_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            s2_last_reg <= s1_last_reg;
            s2_m_reg    <= bb3_pkg::recip(count);
            for (int ch = 0; ch < 3; ch++)
                s2_num_reg[ch] <= num[ch];
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            prod[ch] = bb3_pkg::PROD_W'(s2_num_reg[ch]) * bb3_pkg::PROD_W'(s2_m_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            out_reg.out_red    <= prod[0][bb3_pkg::RECIP_SH +: CW];
            out_reg.out_green  <= prod[1][bb3_pkg::RECIP_SH +: CW];
            out_reg.out_blue   <= prod[2][bb3_pkg::RECIP_SH +: CW];
            out_reg.frame_last <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `BB3_ASSERT_ALWAYS(a_row_sat, row_reg != 2'd3, "row count left its range")
    `BB3_ASSERT_ALWAYS(a_pos_range, (col_reg <= wm1) && (cc_reg <= wm1) && (rc_reg <= hm1), "position beyond frame")
    `BB3_ASSERT_NEXT(a_last_restart, accept && last, (col_reg == '0) && (cc_reg == '0) && (rc_reg == '0), "frame not restarted after final item")
    `BB3_ASSERT_NEXT(a_emit_flows, adv && s1_valid_reg && s1_emit_reg, s2_valid_reg, "emitting item lost between stages")

endmodule

`default_nettype wire
